[rtl/tdss_pkg.sv]
`timescale 1ns / 1ps
// Package for the two-digit segment serializer: item and job types, codes and reset values.
// Used by every module of the block; depends on nothing.

package tdss_pkg;

    // Input item selector codes.
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_COMMAND = 2'd1;
    localparam logic [1:0] CMD_WRITE   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TICK_PERIOD = 2'd0;
    localparam logic [1:0] CFG_SEG_FIRST   = 2'd1;
    localparam logic [1:0] CFG_SEG_SECOND  = 2'd2;

    localparam int CFG_DATA_W  = 40;
    localparam int PERIOD_W    = 16;
    localparam int SEG_TABLE_W = 40;

    localparam logic [PERIOD_W-1:0]    PERIOD_RESET     = 16'd61;
    localparam logic [SEG_TABLE_W-1:0] SEG_FIRST_RESET  = 40'hBF1FB29D0F;
    localparam logic [SEG_TABLE_W-1:0] SEG_SECOND_RESET = 40'h7F56677355;

    // Frame prefixes sent ahead of the payload bits.
    localparam logic [2:0] PREFIX_COMMAND = 3'b100;
    localparam logic [2:0] PREFIX_WRITE   = 3'b101;

    // Depth of the job queue between the front and back ends.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] cmd_byte;
        logic [5:0] addr;
        logic [3:0] nibble;
    } t_in_item;

    typedef struct packed {
        logic data_bit;
        logic frame_end;
        logic last;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_COMMAND,
        JOB_WRITE,
        JOB_UPDATE
    } t_job_kind;

    // One unit of serial work. Command: byte in [7:0]. Write: address in [9:4],
    // nibble in [3:0]. Update: nibbles for addresses 7, 6, 5, 4 from [15:12] down.
    typedef struct packed {
        t_job_kind   kind;
        logic [15:0] data;
    } t_job;

endpackage

[rtl/tdss_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input items, holds configuration, tick counter and the shown digits,
// and turns each item into a serial job. Depends on tdss_pkg.

module tdss_front
    import tdss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_item,
    output logic                  o_in_stall,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [PERIOD_W-1:0]    r_period;
    logic [SEG_TABLE_W-1:0] r_seg_first;
    logic [SEG_TABLE_W-1:0] r_seg_second;
    logic [PERIOD_W-1:0]    r_count;
    logic [3:0]             r_tens;
    logic [3:0]             r_units;

    logic                   accept;
    logic [PERIOD_W:0]      count_inc;
    logic                   roll;
    logic [3:0]             n_tens;
    logic [3:0]             n_units;

    assign accept = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    // The number advances once the incremented count reaches the period.
    assign count_inc = {1'b0, r_count} + {{PERIOD_W{1'b0}}, 1'b1};
    assign roll      = count_inc >= {1'b0, r_period};

    // Next shown number, kept as two decimal digits so no division is needed.
    always_comb begin
        if (r_units == 4'd9) begin
            n_units = 4'd0;
            n_tens  = (r_tens == 4'd9) ? 4'd0 : r_tens + 4'd1;
        end else begin
            n_units = r_units + 4'd1;
            n_tens  = r_tens;
        end
    end

    // Classify the item and build its job.
    always_comb begin
        o_push     = 1'b0;
        o_job.kind = JOB_COMMAND;
        o_job.data = 16'd0;
        case (i_in_item.cmd)
            CMD_COMMAND: begin
                o_push     = accept;
                o_job.kind = JOB_COMMAND;
                o_job.data = {8'd0, i_in_item.cmd_byte};
            end
            CMD_WRITE: begin
                o_push     = accept;
                o_job.kind = JOB_WRITE;
                o_job.data = {6'd0, i_in_item.addr, i_in_item.nibble};
            end
            CMD_TICK: begin
                o_push     = accept && roll;
                o_job.kind = JOB_UPDATE;
                o_job.data = {r_seg_first[{n_tens, 2'b00} +: 4],
                              r_seg_second[{n_tens, 2'b00} +: 4],
                              r_seg_first[{n_units, 2'b00} +: 4],
                              r_seg_second[{n_units, 2'b00} +: 4]};
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= PERIOD_RESET;
            r_seg_first  <= SEG_FIRST_RESET;
            r_seg_second <= SEG_SECOND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TICK_PERIOD: r_period     <= i_cfg_data[PERIOD_W-1:0];
                CFG_SEG_FIRST:   r_seg_first  <= i_cfg_data[SEG_TABLE_W-1:0];
                CFG_SEG_SECOND:  r_seg_second <= i_cfg_data[SEG_TABLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Tick counter and shown digits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tens  <= 4'd0;
            r_units <= 4'd0;
        end else if (accept && i_in_item.cmd == CMD_TICK) begin
            if (roll) begin
                r_count <= '0;
                r_tens  <= n_tens;
                r_units <= n_units;
            end else begin
                r_count <= count_inc[PERIOD_W-1:0];
            end
        end
    end

endmodule

[rtl/tdss_queue.sv]
`timescale 1ns / 1ps
// Short job queue between the front and back ends.
// Depends on tdss_pkg for the job type.

module tdss_queue
    import tdss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/tdss_back.sv]
`timescale 1ns / 1ps
// Back end: takes jobs from the queue and shifts out their frames one bit per cycle
// into a registered output stage while the output is not stalled. Depends on tdss_pkg.

module tdss_back
    import tdss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic        r_busy;
    t_job_kind   r_kind;
    logic [15:0] r_data;
    logic [1:0]  r_frame;
    logic [3:0]  r_bit;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic [12:0] frame_word;
    logic [3:0]  bit_last;
    logic [5:0]  upd_addr;
    logic [3:0]  upd_nibble;
    logic [3:0]  bit_idx;
    logic        frame_done;
    logic        job_done;
    logic        advance;

    // Update jobs walk addresses 7 down to 4.
    always_comb begin
        upd_addr = 6'd7 - {4'd0, r_frame};
        case (r_frame)
            2'd0:    upd_nibble = r_data[15:12];
            2'd1:    upd_nibble = r_data[11:8];
            2'd2:    upd_nibble = r_data[7:4];
            default: upd_nibble = r_data[3:0];
        endcase
    end

    // Current frame, left aligned in 13 bits, and the index of its final bit.
    always_comb begin
        case (r_kind)
            JOB_COMMAND: begin
                frame_word = {PREFIX_COMMAND, r_data[7:0], 2'b00};
                bit_last   = 4'd11;
            end
            JOB_WRITE: begin
                frame_word = {PREFIX_WRITE, r_data[9:0]};
                bit_last   = 4'd12;
            end
            JOB_UPDATE: begin
                frame_word = {PREFIX_WRITE, upd_addr, upd_nibble};
                bit_last   = 4'd12;
            end
            default: begin
                frame_word = '0;
                bit_last   = 4'd12;
            end
        endcase
    end

    assign bit_idx    = 4'd12 - r_bit;
    assign frame_done = (r_bit == bit_last);
    assign job_done   = frame_done && (r_kind != JOB_UPDATE || r_frame == 2'd3);
    assign advance    = !r_out_valid || !i_out_stall;

    // Take the next job when idle, or in the same cycle the last bit leaves.
    assign o_pop = i_q_valid && (!r_busy || (advance && job_done));

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Output stage payload.
    always_ff @(posedge i_clk) begin
        if (advance && r_busy) begin
            r_out_item.data_bit  <= frame_word[bit_idx];
            r_out_item.frame_end <= frame_done;
            r_out_item.last      <= job_done;
        end
    end

    // Job and bit position control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_kind      <= JOB_COMMAND;
            r_data      <= 16'd0;
            r_frame     <= 2'd0;
            r_bit       <= 4'd0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
            end
            if (advance && r_busy) begin
                if (frame_done) begin
                    r_bit   <= 4'd0;
                    r_frame <= r_frame + 2'd1;
                end else begin
                    r_bit <= r_bit + 4'd1;
                end
                if (job_done) begin
                    r_busy <= 1'b0;
                end
            end
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_kind  <= i_q_job.kind;
                r_data  <= i_q_job.data;
                r_frame <= 2'd0;
                r_bit   <= 4'd0;
            end
        end
    end

endmodule

[rtl/ticked_two_digit_segment_serializer.sv]
`timescale 1ns / 1ps
// Top level of the two-digit segment serializer: front end, job queue and serial back end.
// Depends on tdss_pkg, tdss_front, tdss_queue and tdss_back.
//
//  Channel   Direction  Handshake                     Payload
//  input     in         i_in_valid / o_in_stall       i_in_item  (t_in_item)
//  output    out        o_out_valid / i_out_stall     o_out_item (t_out_item)
//  config    in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// A command item is a 12-bit frame, a write item a 13-bit frame and a tick that advances
// the number four 13-bit frames, sent one bit per cycle while the output is not stalled.
// A tick that does not advance the number, or an unused selector, makes no job. When the
// back end is free, a transaction's first bit passes through the job queue, the back
// end's job registers and the output stage. The input stalls only when the job queue is
// full; output stalls freeze the back end. Reset is synchronous and needs no clearing pass.

module ticked_two_digit_segment_serializer
    import tdss_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic q_full;
    logic q_push;
    t_job q_push_job;
    logic q_pop;
    logic q_valid;
    t_job q_head;

    // Front end: classification and display state.
    tdss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (q_push_job)
    );

    // Job queue.
    tdss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_head)
    );

    // Serial back end.
    tdss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/tdss_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the two-digit segment serializer, bound to the top level.
// Depends on tdss_pkg for the item types.

module tdss_checker
    import tdss_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_item
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output changed while stalled");

    // Reset empties the output stage.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset empties the job queue, so the input is open.
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // The final bit of a transaction always closes a frame.
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last |-> o_out_item.frame_end)
        else $error("last bit without frame end");

endmodule

bind ticked_two_digit_segment_serializer tdss_checker u_tdss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
